// ===== rtl/sofx_pkg.sv =====
// Shared types and constants for the SOF / length / XOR frame receiver.
`timescale 1ns / 1ps
`default_nettype none

package sofx_pkg;

   // Frame buffer depth in bytes (2..256)
   localparam int unsigned BUF_DEPTH = 64;

   localparam int unsigned POS_W = 9;
   localparam logic [POS_W-1:0] BUF_DEPTH_POS = POS_W'(BUF_DEPTH);

   localparam logic [7:0]  START_BYTE_RESET    = 8'd170;
   localparam logic [15:0] TIMEOUT_TICKS_RESET = 16'd100;

   typedef enum logic [0:0] {
      CSR_START_BYTE    = 1'b0,
      CSR_TIMEOUT_TICKS = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_NONE     = 2'd0,
      ST_RECEIVED = 2'd1,
      ST_ERROR    = 2'd2,
      ST_TIMEOUT  = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      PH_HUNT = 3'b001,
      PH_DATA = 3'b010,
      PH_CXOR = 3'b100
   } phase_type;

   typedef struct packed {
      logic [7:0]  start_byte;
      logic [15:0] timeout_ticks;
   } cfg_type;

   typedef struct packed {
      status_type status;
      logic       data_valid;
      logic [7:0] byte_pos;
      logic [7:0] data_byte;
   } result_type;

endpackage

`default_nettype wire

// ===== rtl/sof_length_xor_frame_receiver.sv =====
// Top level of the SOF / length / XOR-checksum frame receiver.
`timescale 1ns / 1ps
`default_nettype none

// Takes one transaction per cycle: either a received serial byte (req_func 0)
// or a millisecond tick (req_func 1), and gives exactly one result
// transaction for each. In hunt, a byte equal to start_byte opens a frame and
// any other byte gives a frame error. The first frame byte is the length L;
// it and the L bytes after it come out with data_valid set and their
// position in rsp_byte_pos. The byte after them is checked against the XOR of
// the start byte and all frame bytes (received or error). A frame that would
// exceed the buffer depth gives an error; timeout_ticks ticks with no byte
// inside an open frame give a timeout. The step logic sits between the
// frame state and a single result register, and req_ready stays high
// while that register is empty or being taken, so a new transaction is
// accepted every cycle under a free-flowing output.
// Configuration writes (csr_we) take effect at once and are meant for idle
// periods only.

module sof_length_xor_frame_receiver
   import sofx_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_func,
   input  wire logic [7:0]  req_rx_byte,

   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_status,
   output logic             rsp_data_valid,
   output logic [7:0]       rsp_byte_pos,
   output logic [7:0]       rsp_data_byte,

   input  wire logic        csr_we,
   input  wire logic [0:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);

   cfg_type    cfg_ff;
   result_type step_result;
   result_type result_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       req_fire;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_byte    <= START_BYTE_RESET;
         cfg_ff.timeout_ticks <= TIMEOUT_TICKS_RESET;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_START_BYTE:    cfg_ff.start_byte    <= csr_wdata[7:0];
            CSR_TIMEOUT_TICKS: cfg_ff.timeout_ticks <= csr_wdata;
            default: ;
         endcase
      end
   end

   // output register frees itself in the same cycle it is taken
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   sofx_engine u_engine (
      .clock   (clock),
      .reset   (reset),
      .step_en (req_fire),
      .func    (req_func),
      .rx_byte (req_rx_byte),
      .cfg     (cfg_ff),
      .result  (step_result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      if (req_fire) begin
         result_ff <= step_result;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = result_ff.status;
   assign rsp_data_valid = result_ff.data_valid;
   assign rsp_byte_pos   = result_ff.byte_pos;
   assign rsp_data_byte  = result_ff.data_byte;

   // an accepted transaction always leaves a result behind
   assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_valid_ff)
      else $error("accepted transaction produced no result");

   // a held result blocks the input side
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !req_ready)
      else $error("input accepted while result stalled");

   // a passed-out frame byte is never a final outcome
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && result_ff.data_valid) |-> (result_ff.status == ST_NONE))
      else $error("data byte carries a final status");

   // byte fields are zero when no frame byte is passed out
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !result_ff.data_valid) |->
         (result_ff.byte_pos == 8'd0 && result_ff.data_byte == 8'd0))
      else $error("byte fields not cleared");

endmodule

`default_nettype wire

// ===== rtl/sofx_engine.sv =====
// Frame state registers and the per-transaction next-state and result logic.
`timescale 1ns / 1ps
`default_nettype none

module sofx_engine
   import sofx_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       step_en,
   input  wire logic       func,
   input  wire logic [7:0] rx_byte,
   input  wire cfg_type    cfg,
   output result_type      result
);

   phase_type        phase_ff,        phase_in;
   logic [POS_W-1:0] position_ff,     position_in;
   logic [7:0]       frame_length_ff, frame_length_in;
   logic [7:0]       running_xor_ff,  running_xor_in;
   logic [15:0]      idle_count_ff,   idle_count_in;

   logic [15:0]      idle_inc;
   logic [POS_W-1:0] pos_inc;
   logic [7:0]       len_eff;

   always_comb begin
      idle_inc = (idle_count_ff == 16'hFFFF) ? idle_count_ff : idle_count_ff + 16'd1;
      pos_inc  = position_ff + POS_W'(1);
      len_eff  = (position_ff == '0) ? rx_byte : frame_length_ff;

      // unused phase codes fall back to hunt
      phase_in        = (phase_ff == PH_DATA || phase_ff == PH_CXOR) ? phase_ff : PH_HUNT;
      position_in     = position_ff;
      frame_length_in = frame_length_ff;
      running_xor_in  = running_xor_ff;
      idle_count_in   = idle_count_ff;
      result          = '{status: ST_NONE, data_valid: 1'b0, byte_pos: 8'd0, data_byte: 8'd0};

      if (func) begin
         // tick: idle time counts only inside an open frame
         unique case (phase_ff)
            PH_DATA, PH_CXOR: begin
               idle_count_in = idle_inc;
               if (idle_inc >= cfg.timeout_ticks) begin
                  result.status = ST_TIMEOUT;
                  phase_in      = PH_HUNT;
                  idle_count_in = 16'd0;
               end
            end
            default: ;
         endcase
      end else begin
         unique case (phase_ff)
            PH_DATA: begin
               idle_count_in = 16'd0;
               if (position_ff < BUF_DEPTH_POS) begin
                  result.data_valid = 1'b1;
                  result.byte_pos   = position_ff[7:0];
                  result.data_byte  = rx_byte;
                  running_xor_in    = running_xor_ff ^ rx_byte;
                  frame_length_in   = len_eff;
                  position_in       = pos_inc;
                  if (pos_inc == {1'b0, len_eff} + POS_W'(1)) begin
                     phase_in = PH_CXOR;
                  end
               end else begin
                  result.status = ST_ERROR;
                  phase_in      = PH_HUNT;
               end
            end
            PH_CXOR: begin
               result.status = (rx_byte == running_xor_ff) ? ST_RECEIVED : ST_ERROR;
               phase_in      = PH_HUNT;
               idle_count_in = 16'd0;
            end
            default: begin
               if (rx_byte == cfg.start_byte) begin
                  phase_in       = PH_DATA;
                  position_in    = '0;
                  running_xor_in = cfg.start_byte;
                  idle_count_in  = 16'd0;
               end else begin
                  result.status = ST_ERROR;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_HUNT;
         position_ff     <= '0;
         frame_length_ff <= 8'd0;
         running_xor_ff  <= 8'd0;
         idle_count_ff   <= 16'd0;
      end else if (step_en) begin
         phase_ff        <= phase_in;
         position_ff     <= position_in;
         frame_length_ff <= frame_length_in;
         running_xor_ff  <= running_xor_in;
         idle_count_ff   <= idle_count_in;
      end
   end

endmodule

`default_nettype wire

// ===== bench/sof_length_xor_frame_receiver_test.sv =====
// Self-checking testbench for the SOF / length / XOR-checksum frame receiver.
`timescale 1ns / 1ps

module sof_length_xor_frame_receiver_test;
   import sofx_pkg::*;

   localparam logic FUNC_BYTE = 1'b0;
   localparam logic FUNC_TICK = 1'b1;
   // cycles with no transaction on either side before the run is abandoned
   localparam int STALL_LIMIT = 5000;
   localparam logic [7:0] STALL_MASK = 8'b1011_0110;

   typedef struct packed {
      logic       func;
      logic [7:0] rx_byte;
   } serial_event_type;

   typedef enum logic [1:0] {
      RX_FLOW,
      RX_SPARSE_STALL,
      RX_PATTERN_STALL,
      RX_HEAVY_STALL
   } rx_stall_mode_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_func = FUNC_BYTE;
   logic [7:0]  req_rx_byte = 8'h00;

   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_status;
   logic        rsp_data_valid;
   logic [7:0]  rsp_byte_pos;
   logic [7:0]  rsp_data_byte;

   logic        csr_we = 1'b0;
   logic [0:0]  csr_index = CSR_START_BYTE;
   logic [15:0] csr_wdata = 16'h0000;

   sof_length_xor_frame_receiver dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_func       (req_func),
      .req_rx_byte    (req_rx_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_data_valid (rsp_data_valid),
      .rsp_byte_pos   (rsp_byte_pos),
      .rsp_data_byte  (rsp_data_byte),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 0;
   end

   // ---------------------------------------------------------------------
   // Deframer prediction: our own copy of the frame state and the registers
   // ---------------------------------------------------------------------
   cfg_type      frame_cfg = '{start_byte: START_BYTE_RESET,
                               timeout_ticks: TIMEOUT_TICKS_RESET};
   phase_type    frame_phase = PH_HUNT;
   logic [8:0]   frame_pos = '0;      // bytes stored so far in the open frame
   logic [7:0]   frame_len = '0;      // length byte of the open frame
   logic [7:0]   frame_xor = '0;      // start byte XOR every stored byte
   logic [15:0]  idle_ticks = '0;     // ticks since the last byte of the frame

   serial_event_type rx_stream[$];    // bytes and ticks still to be sent
   result_type    awaited_results[$]; // predicted results, oldest first

   int mismatches = 0;
   int items_queued = 0;
   int accepted_items = 0;
   int frames_received = 0;
   int frame_errors = 0;
   int timeouts = 0;
   int data_bytes = 0;
   int settings_used = 1;             // the reset setting counts as one

   // One step of the receiver: advances the frame state, returns the result.
   function automatic result_type deframe_step(input logic func, input logic [7:0] b);
      result_type r;
      r = '0;
      r.status = ST_NONE;
      if (func == FUNC_TICK) begin
         // ticks only matter while a frame is open; the count saturates
         if (frame_phase != PH_HUNT) begin
            if (idle_ticks != 16'hFFFF)
               idle_ticks = idle_ticks + 16'd1;
            if (idle_ticks >= frame_cfg.timeout_ticks) begin
               r.status = ST_TIMEOUT;
               frame_phase = PH_HUNT;
               idle_ticks = '0;
            end
         end
      end else if (frame_phase == PH_HUNT) begin
         if (b == frame_cfg.start_byte) begin
            frame_phase = PH_DATA;
            frame_pos = '0;
            frame_xor = frame_cfg.start_byte;
            idle_ticks = '0;
         end else begin
            r.status = ST_ERROR;   // stray byte, stay hunting
         end
      end else if (frame_phase == PH_DATA) begin
         idle_ticks = '0;
         if (frame_pos < BUF_DEPTH_POS) begin
            r.data_valid = 1'b1;
            r.byte_pos = frame_pos[7:0];
            r.data_byte = b;
            frame_xor = frame_xor ^ b;
            if (frame_pos == '0)
               frame_len = b;
            frame_pos = frame_pos + 9'd1;
            if (frame_pos == {1'b0, frame_len} + 9'd1)
               frame_phase = PH_CXOR;
         end else begin
            // buffer full: byte refused, frame dropped
            r.status = ST_ERROR;
            frame_phase = PH_HUNT;
            idle_ticks = '0;
         end
      end else begin
         r.status = (b == frame_xor) ? ST_RECEIVED : ST_ERROR;
         frame_phase = PH_HUNT;
         idle_ticks = '0;
      end
      return r;
   endfunction

   task automatic flag_mismatch(input string msg);
      $display("%0t ns: MISMATCH %s", $time, msg);
      mismatches++;
   endtask

   // ---------------------------------------------------------------------
   // Driver: bursts of random length from rx_stream, random gaps between.
   // Each accepted transaction is predicted at the edge that takes it.
   // ---------------------------------------------------------------------
   int               burst_left = 0;
   int               gap_left = 0;
   serial_event_type next_event;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            awaited_results.push_back(deframe_step(req_func, req_rx_byte));
            accepted_items++;
         end
         // only move on once the current transaction has gone
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (rx_stream.size() != 0) begin
               next_event = rx_stream.pop_front();
               req_valid <= 1'b1;
               req_func <= next_event.func;
               req_rx_byte <= next_event.rx_byte;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 30);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: field-by-field check against the oldest prediction, plus the
   // receiver's stall pattern, which switches mode every so often.
   // ---------------------------------------------------------------------
   rx_stall_mode_type stall_mode = RX_FLOW;
   int                mode_left = 0;
   logic [7:0]        stall_shift = STALL_MASK;
   result_type        want;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (awaited_results.size() == 0) begin
               flag_mismatch($sformatf("result with nothing expected (status %0d)",
                                       rsp_status));
            end else begin
               want = awaited_results.pop_front();
               if (rsp_status !== want.status)
                  flag_mismatch($sformatf("status: got %0d, expected %0d",
                                          rsp_status, want.status));
               if (rsp_data_valid !== want.data_valid)
                  flag_mismatch($sformatf("data_valid: got %0b, expected %0b",
                                          rsp_data_valid, want.data_valid));
               if (rsp_byte_pos !== want.byte_pos)
                  flag_mismatch($sformatf("byte_pos: got %0d, expected %0d",
                                          rsp_byte_pos, want.byte_pos));
               if (rsp_data_byte !== want.data_byte)
                  flag_mismatch($sformatf("data_byte: got %02h, expected %02h",
                                          rsp_data_byte, want.data_byte));
               case (want.status)
                  ST_RECEIVED: frames_received++;
                  ST_ERROR:    frame_errors++;
                  ST_TIMEOUT:  timeouts++;
                  default:     if (want.data_valid) data_bytes++;
               endcase
            end
         end
         if (mode_left == 0) begin
            stall_mode = rx_stall_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(32, 200);
         end else begin
            mode_left--;
         end
         stall_shift = {stall_shift[6:0], stall_shift[7]};
         case (stall_mode)
            RX_FLOW:          rsp_ready <= 1'b1;
            RX_SPARSE_STALL:  rsp_ready <= ($urandom_range(0, 3) != 0);
            RX_PATTERN_STALL: rsp_ready <= stall_shift[0];
            default:          rsp_ready <= ($urandom_range(0, 2) == 0);
         endcase
      end
   end

   // watchdog: no transaction anywhere for too long means the block has hung
   int quiet_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_we) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Timed out after %0d quiet cycles", STALL_LIMIT);
         $display("sof_length_xor_frame_receiver_test: FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus building
   // ---------------------------------------------------------------------
   task automatic push_byte(input logic [7:0] b);
      rx_stream.push_back('{func: FUNC_BYTE, rx_byte: b});
      items_queued++;
   endtask

   task automatic push_ticks(input int n);
      repeat (n) begin
         rx_stream.push_back('{func: FUNC_TICK, rx_byte: 8'($urandom)});
         items_queued++;
      end
   endtask

   // a few idle ticks inside a frame, always short of the timeout
   task automatic maybe_idle_ticks();
      int t;
      t = frame_cfg.timeout_ticks;
      if (t > 1 && $urandom_range(0, 7) == 0)
         push_ticks($urandom_range(1, (t - 1 < 4) ? t - 1 : 4));
   endtask

   // Mostly well-formed frames with random content; some are cut short,
   // overrun the buffer, carry a bad checksum or are left to time out.
   task automatic add_frame();
      int         sel;
      int         len;
      int         cut;
      int         tmo_at;
      int         i;
      int         t;
      logic [7:0] x;
      logic [7:0] val;
      t = frame_cfg.timeout_ticks;
      sel = $urandom_range(0, 15);
      case (sel)
         0:       len = $urandom_range(64, 254);
         1:       len = 255;
         2:       len = BUF_DEPTH - 1;
         3:       len = 0;
         default: len = $urandom_range(1, 12);
      endcase
      cut = ($urandom_range(0, 14) == 0) ? $urandom_range(0, len) : -1;
      tmo_at = (t <= 300 && $urandom_range(0, 11) == 0) ? $urandom_range(0, len + 1) : -1;
      push_byte(frame_cfg.start_byte);
      x = frame_cfg.start_byte;
      for (i = 0; i <= len && i < BUF_DEPTH; i++) begin
         if (i == cut)
            return;
         if (i == tmo_at) begin
            push_ticks(t);
            return;
         end
         maybe_idle_ticks();
         val = (i == 0) ? 8'(len) : 8'($urandom);
         push_byte(val);
         x = x ^ val;
      end
      if (len >= BUF_DEPTH) begin
         push_byte(8'($urandom));   // no room left for this one
         return;
      end
      if (tmo_at == len + 1) begin
         push_ticks(t);
         return;
      end
      maybe_idle_ticks();
      push_byte(($urandom_range(0, 6) == 0) ? x ^ (8'd1 << $urandom_range(0, 7)) : x);
   endtask

   // noise between frames: stray bytes and ticks while hunting
   task automatic add_noise();
      repeat ($urandom_range(1, 3)) begin
         if ($urandom_range(0, 2) == 0)
            push_ticks(1);
         else
            push_byte(8'($urandom));
      end
   endtask

   task automatic add_random_traffic(input int target);
      int first;
      first = items_queued;
      while (items_queued - first < target) begin
         add_frame();
         if ($urandom_range(0, 3) == 0)
            add_noise();
      end
   endtask

   // idle = nothing left to send, nothing in flight, nothing awaited
   task automatic wait_idle();
      do
         @(negedge clock);
      while (rx_stream.size() != 0 || req_valid || awaited_results.size() != 0);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [15:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_START_BYTE:    frame_cfg.start_byte = value[7:0];
         CSR_TIMEOUT_TICKS: frame_cfg.timeout_ticks = value;
         default:           ;
      endcase
   endtask

   // ---------------------------------------------------------------------
   // Test sequence: reset setting first, then extremes, then random ones.
   // ---------------------------------------------------------------------
   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // reset setting: start byte AA, timeout 100
      push_ticks(1);                                 // tick while hunting
      push_byte(8'h00);                              // stray bytes
      push_byte(8'hFF);
      push_byte(8'hAA); push_byte(8'h00); push_byte(8'hAA);   // empty frame
      // start value inside the payload is plain data
      push_byte(8'hAA); push_byte(8'h01); push_byte(8'hAA); push_byte(8'h01);
      // bad checksum (correct would be 57)
      push_byte(8'hAA); push_byte(8'h02); push_byte(8'h80); push_byte(8'h7F);
      push_byte(8'h56);
      // idle ticks inside a frame, short of the timeout
      push_byte(8'hAA); push_byte(8'h01); push_ticks(2); push_byte(8'h55);
      push_ticks(1); push_byte(8'hFE);
      add_random_traffic(280);
      wait_idle();

      // lowest start byte, shortest timeout
      write_reg(CSR_START_BYTE, 16'h0000);
      write_reg(CSR_TIMEOUT_TICKS, 16'd1);
      settings_used++;
      push_byte(8'h00); push_byte(8'h05); push_ticks(1);      // timeout mid-frame
      push_byte(8'h00); push_byte(8'h00); push_ticks(1);      // timeout on checksum
      add_random_traffic(200);
      wait_idle();

      // highest start byte, longest timeout
      write_reg(CSR_START_BYTE, 16'h00FF);
      write_reg(CSR_TIMEOUT_TICKS, 16'hFFFF);
      settings_used++;
      push_byte(8'hFF); push_byte(8'h00); push_byte(8'hFF);
      add_random_traffic(200);
      wait_idle();

      // random start byte, short random timeout so timeouts come often
      write_reg(CSR_START_BYTE, 16'($urandom_range(0, 255)));
      write_reg(CSR_TIMEOUT_TICKS, 16'($urandom_range(2, 40)));
      settings_used++;
      add_random_traffic(200);
      wait_idle();

      // fully random setting
      write_reg(CSR_TIMEOUT_TICKS, 16'($urandom_range(1, 65535)));
      write_reg(CSR_START_BYTE, 16'($urandom_range(0, 255)));
      settings_used++;
      add_random_traffic(200);
      wait_idle();

      if (awaited_results.size() != 0)
         flag_mismatch($sformatf("%0d results never arrived", awaited_results.size()));

      $display("Run covered %0d transactions over %0d register settings, %0d mismatches",
               accepted_items, settings_used, mismatches);
      $display("Outcomes: %0d frames received, %0d frame errors, %0d timeouts, %0d data bytes",
               frames_received, frame_errors, timeouts, data_bytes);
      if (mismatches == 0) begin
         $display("sof_length_xor_frame_receiver_test: PASS");
      end else begin
         $display("sof_length_xor_frame_receiver_test: FAIL");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/sofx_pkg.sv
rtl/sofx_engine.sv
rtl/sof_length_xor_frame_receiver.sv
bench/sof_length_xor_frame_receiver_test.sv
